@@ rtl/one_wire_master_byte_engine_unit_defines.svh @@
// Assertion macros shared by the checker of the 1-Wire master byte engine.
// No dependencies; included by the files that assert.
`ifndef ONE_WIRE_MASTER_BYTE_ENGINE_UNIT_DEFINES_SVH
`define ONE_WIRE_MASTER_BYTE_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define OWM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("owm check failed: same-cycle rule");

// Next-cycle implication, disabled during reset.
`define OWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("owm check failed: next-cycle rule");

`endif

@@ rtl/owm_pkg.sv @@
// Shared constants, codes and types of the 1-Wire master byte engine.
// No dependencies.
`default_nettype none

package owm_pkg;

   localparam int TIMER_WIDTH_DEF = 10;
   localparam int BITS_PER_BYTE   = 8;
   localparam int CFG_W           = 10;
   localparam int CFG_IDX_W       = 3;
   localparam int KIND_W          = 2;
   localparam int BYTE_W          = 8;
   localparam int PHASE_W         = 3;
   localparam int BIT_IDX_W       = 3;

   // item kinds; the command kinds double as operation codes
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RESET = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

   localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
   localparam logic [PHASE_W-1:0] PH_RST_LOW   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_RST_WAIT  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_RST_TAIL  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_SLOT_LOW  = 3'd4;
   localparam logic [PHASE_W-1:0] PH_SLOT_REST = 3'd5;
   localparam logic [PHASE_W-1:0] PH_RECOVERY  = 3'd6;

   localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW     = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_SLOT          = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_RECOVERY      = 3'd5;

   localparam logic [CFG_W-1:0] INIT_RESET_LOW     = 10'd480;
   localparam logic [CFG_W-1:0] INIT_PRESENCE_WAIT = 10'd80;
   localparam logic [CFG_W-1:0] INIT_RESET_TAIL    = 10'd400;
   localparam logic [CFG_W-1:0] INIT_SHORT_LOW     = 10'd1;
   localparam logic [CFG_W-1:0] INIT_SLOT          = 10'd50;
   localparam logic [CFG_W-1:0] INIT_RECOVERY      = 10'd1;

   typedef struct packed {
      logic [CFG_W-1:0] reset_low;
      logic [CFG_W-1:0] presence_wait;
      logic [CFG_W-1:0] reset_tail;
      logic [CFG_W-1:0] short_low;
      logic [CFG_W-1:0] slot;
      logic [CFG_W-1:0] recovery;
   } cfg_regs_type;

endpackage

`default_nettype wire

@@ rtl/owm_ifs.sv @@
// Valid/ready channel interfaces of the 1-Wire master byte engine.
// Depends on owm_pkg for field widths.
`default_nettype none

interface owm_req_if;
   logic                          valid;
   logic                          ready;
   logic [owm_pkg::KIND_W-1:0]    kind;
   logic [owm_pkg::BYTE_W-1:0]    data_byte;
   logic                          line_level;
   modport source (output valid, kind, data_byte, line_level, input ready);
   modport sink   (input valid, kind, data_byte, line_level, output ready);
endinterface

interface owm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          drive_low;
   logic                          busy_res;
   logic                          done_res;
   logic                          presence;
   logic [owm_pkg::BYTE_W-1:0]    read_byte;
   logic                          rejected;
   modport source (output valid, drive_low, busy_res, done_res, presence, read_byte,
                   rejected, input ready);
   modport sink   (input valid, drive_low, busy_res, done_res, presence, read_byte,
                   rejected, output ready);
endinterface

interface owm_csr_if;
   logic                            valid;
   logic                            ready;
   logic [owm_pkg::CFG_IDX_W-1:0]   index;
   logic [owm_pkg::CFG_W-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/one_wire_master_byte_engine_unit.sv @@
// 1-Wire bus master byte engine, stepped by tick and command words.
// A result word is registered and appears the cycle after its request word is taken.
// Throughput: one request word per cycle; an unread result holds requests until read.
// Config writes take effect the cycle after the write; csr ready is high outside reset.
// Synchronous reset clears sequencer, presence, valid, read byte; loads default timings.
// Depends on owm_pkg, owm_ifs and owm_csr.
`default_nettype none

module one_wire_master_byte_engine_unit #(
   parameter int TIMER_WIDTH = owm_pkg::TIMER_WIDTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   owm_req_if.sink   req_ch,
   owm_rsp_if.source rsp_ch,
   owm_csr_if.sink   csr_ch
);

   localparam int CW = (TIMER_WIDTH > owm_pkg::CFG_W) ? TIMER_WIDTH : owm_pkg::CFG_W;
   localparam int BW = owm_pkg::BYTE_W;

   owm_pkg::cfg_regs_type cfg;

   owm_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // clamp a length register to what the tick counter can hold
   function automatic logic [TIMER_WIDTH-1:0] sat(input logic [owm_pkg::CFG_W-1:0] r);
      logic [CW-1:0] r_ext;
      logic [CW-1:0] m_ext;
      r_ext = CW'(r);
      m_ext = CW'({TIMER_WIDTH{1'b1}});
      sat   = (r_ext > m_ext) ? m_ext[TIMER_WIDTH-1:0] : r_ext[TIMER_WIDTH-1:0];
   endfunction

   logic [owm_pkg::PHASE_W-1:0]   phase_ff, phase_in;
   logic [owm_pkg::KIND_W-1:0]    op_ff, op_in;
   logic [TIMER_WIDTH-1:0]        tick_ff, tick_in;
   logic [owm_pkg::BIT_IDX_W-1:0] bit_ff, bit_in;
   logic [BW-1:0]                 shift_ff, shift_in;
   logic                          presence_ff, presence_in;
   logic [BW-1:0]                 last_read_ff, last_read_in;

   logic                          rsp_valid_ff;
   logic                          drive_ff, busy_ff, done_ff, rej_ff;

   logic                          req_fire;
   logic                          drive, done, rej, finish;
   logic                          low_phase, zero_bit, last_bit;
   logic [TIMER_WIDTH-1:0]        lim_sel, lim_tail, lim_rec, tick_adv;
   logic [TIMER_WIDTH:0]          tick_sum;
   logic                          ends;

   assign req_ch.ready = (!rsp_valid_ff || rsp_ch.ready) && !reset;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign lim_tail  = sat(cfg.reset_tail);
   assign lim_rec   = sat(cfg.recovery);
   assign low_phase = (phase_ff == owm_pkg::PH_RST_LOW) || (phase_ff == owm_pkg::PH_SLOT_LOW);
   assign zero_bit  = (op_ff == owm_pkg::KIND_WRITE) && !shift_ff[0];
   assign last_bit  = (bit_ff == owm_pkg::BIT_IDX_W'(owm_pkg::BITS_PER_BYTE - 1));

   always_comb begin
      case (phase_ff)
         owm_pkg::PH_RST_LOW:   lim_sel = sat(cfg.reset_low);
         owm_pkg::PH_RST_WAIT:  lim_sel = sat(cfg.presence_wait);
         owm_pkg::PH_RST_TAIL:  lim_sel = lim_tail;
         owm_pkg::PH_SLOT_LOW:  lim_sel = zero_bit ? sat(cfg.slot) : sat(cfg.short_low);
         owm_pkg::PH_SLOT_REST: lim_sel = sat(cfg.slot);
         owm_pkg::PH_RECOVERY:  lim_sel = lim_rec;
         default:               lim_sel = '0;
      endcase
   end

   assign tick_sum = {1'b0, tick_ff} + {{TIMER_WIDTH{1'b0}}, 1'b1};
   assign ends     = tick_sum >= {1'b0, lim_sel};
   assign tick_adv = ends ? '0 : tick_sum[TIMER_WIDTH-1:0];

   always_comb begin
      phase_in     = phase_ff;
      op_in        = op_ff;
      tick_in      = tick_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      presence_in  = presence_ff;
      last_read_in = last_read_ff;
      drive        = 1'b0;
      done         = 1'b0;
      rej          = 1'b0;
      finish       = 1'b0;
      if (req_ch.kind != owm_pkg::KIND_TICK) begin
         if (phase_ff != owm_pkg::PH_IDLE) begin
            rej   = 1'b1;
            drive = low_phase;
         end else begin
            op_in   = req_ch.kind;
            tick_in = '0;
            bit_in  = '0;
            if (req_ch.kind == owm_pkg::KIND_RESET) begin
               phase_in = owm_pkg::PH_RST_LOW;
            end else begin
               phase_in = owm_pkg::PH_SLOT_LOW;
               shift_in = (req_ch.kind == owm_pkg::KIND_WRITE) ? req_ch.data_byte : '0;
            end
         end
      end else begin
         drive = low_phase;
         case (phase_ff)
            owm_pkg::PH_RST_LOW: begin
               tick_in = tick_adv;
               if (ends) phase_in = owm_pkg::PH_RST_WAIT;
            end
            owm_pkg::PH_RST_WAIT: begin
               tick_in = tick_adv;
               if (ends) begin
                  presence_in = !req_ch.line_level;
                  if (lim_tail == '0) begin
                     phase_in = owm_pkg::PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     phase_in = owm_pkg::PH_RST_TAIL;
                  end
               end
            end
            owm_pkg::PH_RST_TAIL: begin
               tick_in = tick_adv;
               if (ends) begin
                  phase_in = owm_pkg::PH_IDLE;
                  done     = 1'b1;
               end
            end
            owm_pkg::PH_SLOT_LOW: begin
               tick_in = tick_adv;
               if (ends) begin
                  if (zero_bit) finish = 1'b1;
                  else phase_in = owm_pkg::PH_SLOT_REST;
               end
            end
            owm_pkg::PH_SLOT_REST: begin
               // read bit is taken on the first released tick of the slot
               if (op_ff == owm_pkg::KIND_READ && tick_ff == '0)
                  shift_in = {req_ch.line_level, shift_ff[BW-1:1]};
               tick_in = tick_adv;
               if (ends) finish = 1'b1;
            end
            owm_pkg::PH_RECOVERY: begin
               tick_in = tick_adv;
               if (ends) phase_in = owm_pkg::PH_SLOT_LOW;
            end
            default: begin
               phase_in = owm_pkg::PH_IDLE;
               tick_in  = '0;
            end
         endcase
         if (finish) begin
            if (op_ff == owm_pkg::KIND_WRITE) shift_in = {1'b0, shift_ff[BW-1:1]};
            tick_in = '0;
            if (last_bit) begin
               if (op_ff == owm_pkg::KIND_READ) last_read_in = shift_in;
               bit_in   = '0;
               phase_in = owm_pkg::PH_IDLE;
               done     = 1'b1;
            end else begin
               bit_in   = bit_ff + 1'b1;
               phase_in = (lim_rec == '0) ? owm_pkg::PH_SLOT_LOW : owm_pkg::PH_RECOVERY;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= owm_pkg::PH_IDLE;
         op_ff        <= '0;
         tick_ff      <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         presence_ff  <= 1'b0;
         last_read_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff     <= phase_in;
            op_ff        <= op_in;
            tick_ff      <= tick_in;
            bit_ff       <= bit_in;
            shift_ff     <= shift_in;
            presence_ff  <= presence_in;
            last_read_ff <= last_read_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload; presence and read byte come straight from state
   always_ff @(posedge clock) begin
      if (req_fire) begin
         drive_ff <= drive;
         busy_ff  <= (phase_in != owm_pkg::PH_IDLE);
         done_ff  <= done;
         rej_ff   <= rej;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.drive_low = drive_ff;
   assign rsp_ch.busy_res  = busy_ff;
   assign rsp_ch.done_res  = done_ff;
   assign rsp_ch.presence  = presence_ff;
   assign rsp_ch.read_byte = last_read_ff;
   assign rsp_ch.rejected  = rej_ff;

endmodule

`default_nettype wire

@@ rtl/owm_csr.sv @@
// Timing register file of the 1-Wire master byte engine.
// Depends on owm_pkg and the csr channel interface.
`default_nettype none

module owm_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   owm_csr_if.sink              csr_ch,
   output owm_pkg::cfg_regs_type cfg
);

   owm_pkg::cfg_regs_type regs_ff, regs_in;
   logic                  wr_fire;

   assign csr_ch.ready = !reset;
   assign wr_fire      = csr_ch.valid && csr_ch.ready;
   assign cfg          = regs_ff;

   always_comb begin
      regs_in = regs_ff;
      if (wr_fire) begin
         case (csr_ch.index)
            owm_pkg::REG_RESET_LOW:     regs_in.reset_low     = csr_ch.data;
            owm_pkg::REG_PRESENCE_WAIT: regs_in.presence_wait = csr_ch.data;
            owm_pkg::REG_RESET_TAIL:    regs_in.reset_tail    = csr_ch.data;
            owm_pkg::REG_SHORT_LOW:     regs_in.short_low     = csr_ch.data;
            owm_pkg::REG_SLOT:          regs_in.slot          = csr_ch.data;
            owm_pkg::REG_RECOVERY:      regs_in.recovery      = csr_ch.data;
            default:                    regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.reset_low     <= owm_pkg::INIT_RESET_LOW;
         regs_ff.presence_wait <= owm_pkg::INIT_PRESENCE_WAIT;
         regs_ff.reset_tail    <= owm_pkg::INIT_RESET_TAIL;
         regs_ff.short_low     <= owm_pkg::INIT_SHORT_LOW;
         regs_ff.slot          <= owm_pkg::INIT_SLOT;
         regs_ff.recovery      <= owm_pkg::INIT_RECOVERY;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/owm_checker.sv @@
// Port-level checker for the 1-Wire master byte engine, bound to the top level.
// Depends on the assertion macro header.
`default_nettype none
`include "one_wire_master_byte_engine_unit_defines.svh"

module owm_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_busy,
   input wire logic rsp_done,
   input wire logic rsp_rejected
);

   logic req_take;
   logic rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   `OWM_ASSERT_NEXT(a_word_yields_result, clock, reset, req_take, rsp_valid)
   `OWM_ASSERT_NEXT(a_no_phantom_result, clock, reset, rsp_take && !req_take, !rsp_valid)
   `OWM_ASSERT_SAME(a_done_ends_command, clock, reset, rsp_valid && rsp_done, !rsp_busy && !rsp_rejected)
   `OWM_ASSERT_NEXT(a_result_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind one_wire_master_byte_engine_unit owm_checker u_owm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_busy     (rsp_ch.busy_res),
   .rsp_done     (rsp_ch.done_res),
   .rsp_rejected (rsp_ch.rejected)
);

`default_nettype wire
